>>> hdl/scsa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// scsa_pkg: shared types and constants for the size-class slab allocator
// Holds status codes, state encoding and controller/datapath interfaces.
// ---------------------------------------------------------------------------
package scsa_pkg;

    localparam int NUM_CLASSES_DEF         = 9;
    localparam int MAX_PAGES_PER_CLASS_DEF = 16;
    localparam int ADDR_BITS_DEF           = 48;
    localparam int STACK_DEPTH             = 16384;
    localparam int STACK_AW                = 14;
    localparam int PAGE_SHIFT_RESET        = 12;
    localparam int PAGE_SHIFT_MIN          = 10;
    localparam int PAGE_SHIFT_MAX          = 16;
    localparam int OUT_ADDR_W              = 48;

    localparam logic [2:0] ST_ALLOC     = 3'd0;
    localparam logic [2:0] ST_LARGE     = 3'd1;
    localparam logic [2:0] ST_OOM       = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_REGION    = 3'd4;
    localparam logic [2:0] ST_TABLEFULL = 3'd5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_RD,
        S_POP_WAIT,
        S_CARVE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_PUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic decode;
        logic pop_rd;
        logic pop_take;
        logic carve_start;
        logic carve_step;
        logic search_start;
        logic search_step;
        logic push;
        logic set_status;
        logic [2:0] status;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic fits;
        logic have_elem;
        logic table_full;
        logic spare_valid;
        logic carve_last;
        logic search_hit;
        logic search_end;
    } t_sts;

endpackage
`default_nettype wire

>>> hdl/scsa_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// scsa_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module scsa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/scsa_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// scsa_ctrl: allocator controller
// Sequences decode, pop, carve, page search and push per transaction.
// ---------------------------------------------------------------------------
module scsa_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_fire,
    input  wire logic           i_out_free,
    input  wire scsa_pkg::t_sts i_sts,
    output scsa_pkg::t_cmd      o_cmd,
    output logic                o_idle
);
    import scsa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (i_in_fire) n_state = S_DECODE;
            S_DECODE: begin
                if (i_sts.is_free)                         n_state = S_SEARCH_RD;
                else if (!i_sts.fits)                      n_state = S_DONE;
                else if (i_sts.have_elem)                  n_state = S_POP_RD;
                else if (i_sts.table_full)                 n_state = S_DONE;
                else if (!i_sts.spare_valid)               n_state = S_DONE;
                else                                       n_state = S_CARVE;
            end
            S_CARVE:      if (i_sts.carve_last) n_state = S_POP_RD;
            S_POP_RD:     n_state = S_POP_WAIT;
            S_POP_WAIT:   n_state = S_DONE;
            S_SEARCH_RD: begin
                if (i_sts.search_end) n_state = S_DONE;
                else                  n_state = S_SEARCH_CMP;
            end
            S_SEARCH_CMP: begin
                if (i_sts.search_hit) n_state = S_PUSH;
                else                  n_state = S_SEARCH_RD;
            end
            S_PUSH:       n_state = S_DONE;
            S_DONE:       if (i_out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_idle = (r_state == S_IDLE);
        o_cmd.load = (r_state == S_IDLE) && i_in_fire;
        unique case (r_state)
            S_IDLE: ;
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_sts.is_free) begin
                    o_cmd.search_start = 1'b1;
                end else if (!i_sts.fits) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_LARGE;
                end else if (i_sts.have_elem) begin
                    o_cmd.status = ST_ALLOC;
                end else if (i_sts.table_full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_TABLEFULL;
                end else if (!i_sts.spare_valid) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OOM;
                end else begin
                    o_cmd.carve_start = 1'b1;
                end
            end
            S_CARVE:      o_cmd.carve_step = 1'b1;
            S_POP_RD:     o_cmd.pop_rd = 1'b1;
            S_POP_WAIT: begin
                o_cmd.pop_take   = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_ALLOC;
            end
            S_SEARCH_RD: begin
                if (i_sts.search_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_REGION;
                end
            end
            S_SEARCH_CMP: begin
                if (!i_sts.search_hit) o_cmd.search_step = 1'b1;
            end
            S_PUSH: begin
                o_cmd.push       = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_FREED;
            end
            S_DONE:       o_cmd.out_load = i_out_free;
            default: ;
        endcase
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("load outside idle");
    a_push_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> $past(i_sts.search_hit))
        else $error("push without page hit");
    a_done_from: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> r_state == S_DONE)
        else $error("result outside done");
    a_carve_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CARVE && i_sts.carve_last) |=> r_state == S_POP_RD)
        else $error("carve did not end in pop");
endmodule
`default_nettype wire

>>> hdl/scsa_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// scsa_dp: allocator datapath
// Class decode, free-stack memory, page tables, carve and search counters.
// ---------------------------------------------------------------------------
module scsa_dp #(
    parameter int NUM_CLASSES         = scsa_pkg::NUM_CLASSES_DEF,
    parameter int MAX_PAGES_PER_CLASS = scsa_pkg::MAX_PAGES_PER_CLASS_DEF,
    parameter int ADDR_BITS           = scsa_pkg::ADDR_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire scsa_pkg::t_cmd i_cmd,
    input  wire logic [4:0]     i_page_shift,
    input  wire logic           i_operation,
    input  wire logic [31:0]    i_size,
    input  wire logic [47:0]    i_address,
    input  wire logic           i_spare_valid,
    input  wire logic [47:0]    i_spare_page,
    output scsa_pkg::t_sts      o_sts,
    output logic [2:0]          o_status,
    output logic [47:0]         o_result_address,
    output logic [22:0]         o_page_count,
    output logic                o_spare_used
);
    import scsa_pkg::*;

    localparam int SEG_DEPTH = STACK_DEPTH / NUM_CLASSES;
    localparam int CW  = $clog2(NUM_CLASSES + 1);
    localparam int PW  = (MAX_PAGES_PER_CLASS > 1) ? $clog2(MAX_PAGES_PER_CLASS) : 1;
    localparam int PCW = $clog2(MAX_PAGES_PER_CLASS + 1);
    localparam int TW  = $clog2(SEG_DEPTH + 1);
    localparam int PTD = NUM_CLASSES * MAX_PAGES_PER_CLASS;
    localparam int PTAW = (PTD > 1) ? $clog2(PTD) : 1;
    localparam int AW  = (ADDR_BITS > 48) ? ADDR_BITS : 48;

    // input item held for the transaction
    logic              r_op;
    logic [31:0]       r_size;
    logic [AW-1:0]     r_addr;
    logic              r_spv;
    logic [AW-1:0]     r_spare;
    logic [4:0]        r_ps;
    logic [AW-1:0]     r_pmask;

    logic [CW-1:0]     r_cls;
    logic [TW-1:0]     r_top [NUM_CLASSES];
    logic [PCW-1:0]    r_pcnt [NUM_CLASSES];

    logic [TW-1:0]     r_carve_n, r_carve_i;
    logic [AW-1:0]     r_carve_a;
    logic [4:0]        r_esh;

    logic [CW-1:0]     r_sc;
    logic [PCW-1:0]    r_sk;

    logic [2:0]        r_status;
    logic [47:0]       r_raddr;
    logic [22:0]       r_pcount;
    logic              r_sused;

    logic [4:0]        eff_ps;
    logic [5:0]        lz_cls;
    logic              small_c;
    logic [AW-1:0]     amask;

    always_comb begin
        if (i_page_shift < 5'(PAGE_SHIFT_MIN))      eff_ps = 5'(PAGE_SHIFT_MIN);
        else if (i_page_shift > 5'(PAGE_SHIFT_MAX)) eff_ps = 5'(PAGE_SHIFT_MAX);
        else                                        eff_ps = i_page_shift;
    end

    assign amask = (ADDR_BITS >= AW) ? '1 : ((AW'(1) << ADDR_BITS) - AW'(1));

    // class = ceil(log2(size)) - 3, floored at 0; sizes here are below 2^16
    logic [16:0] sm1;
    always_comb begin
        sm1    = (r_size == 32'd0) ? 17'd0 : 17'(r_size - 32'd1);
        lz_cls = 6'd0;
        for (int b = 0; b < 17; b++) begin
            if (sm1[b]) lz_cls = 6'(b + 1);
        end
        lz_cls = (lz_cls > 6'd3) ? lz_cls - 6'd3 : 6'd0;
    end

    logic small_sz;
    assign small_sz = ({r_size, 1'b0} <= (33'd1 << r_ps));
    assign small_c  = small_sz && (lz_cls < 6'(NUM_CLASSES));

    logic [CW-1:0] cls_c;
    assign cls_c = CW'(lz_cls);

    // push targets the hit class
    logic [CW-1:0]       cls_sel;
    logic [STACK_AW-1:0] seg_base;
    logic [TW-1:0]       top_c;
    assign cls_sel  = i_cmd.push ? r_sc : r_cls;
    assign top_c    = r_top[cls_sel];
    assign seg_base = STACK_AW'(cls_sel * SEG_DEPTH);

    // memories
    logic                we_s;
    logic [STACK_AW-1:0] wa_s, ra_s;
    logic [AW-1:0]       wd_s, rd_s;

    always_comb begin
        we_s = 1'b0;
        wa_s = seg_base + STACK_AW'(top_c);
        wd_s = r_carve_a;
        if (i_cmd.carve_step && top_c < TW'(SEG_DEPTH)) we_s = 1'b1;
        if (i_cmd.push) begin
            wd_s = r_addr;
            we_s = (top_c < TW'(SEG_DEPTH));
        end
        ra_s = seg_base + STACK_AW'(top_c - TW'(1));
    end

    scsa_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(we_s), .i_waddr(wa_s), .i_wdata(wd_s),
        .i_raddr(ra_s), .o_rdata(rd_s)
    );

    logic            we_p;
    logic [PTAW-1:0] wa_p, ra_p;
    logic [AW-1:0]   rd_p;
    assign we_p = i_cmd.carve_start;
    assign wa_p = PTAW'(cls_c * MAX_PAGES_PER_CLASS + int'(r_pcnt[cls_c]));
    assign ra_p = PTAW'(r_sc * MAX_PAGES_PER_CLASS + int'(r_sk[PW-1:0]));

    logic [AW-1:0] spare_al;
    assign spare_al = r_spare & amask & r_pmask;

    scsa_ram #(.WIDTH(AW), .DEPTH(PTD)) u_pages (
        .i_clk(i_clk), .i_we(we_p), .i_waddr(wa_p), .i_wdata(spare_al),
        .i_raddr(ra_p), .o_rdata(rd_p)
    );

    logic [AW-1:0] pstart;
    assign pstart = r_addr & r_pmask;

    // search state: end when past last class; hop classes with no more pages
    logic s_end;
    assign s_end = (r_sc >= CW'(NUM_CLASSES)) || (32'(r_sc) >= NUM_CLASSES);

    always_comb begin
        o_sts.is_free     = r_op == OP_FREE;
        o_sts.fits        = small_c;
        o_sts.have_elem   = r_top[cls_c] != '0;
        o_sts.table_full  = r_pcnt[cls_c] >= PCW'(MAX_PAGES_PER_CLASS);
        o_sts.spare_valid = r_spv;
        o_sts.carve_last  = (r_carve_i + TW'(1)) >= r_carve_n;
        o_sts.search_hit  = rd_p == pstart;
        o_sts.search_end  = s_end;
    end

    logic [4:0] esh_c;
    logic [4:0] nsh;
    logic [TW-1:0] ncarve;
    assign esh_c  = 5'(3 + int'(cls_c));
    assign nsh    = r_ps - esh_c;
    assign ncarve = ((17'd1 << nsh) > 17'(SEG_DEPTH)) ? TW'(SEG_DEPTH) : TW'(17'd1 << nsh);

    // advance to next valid (class, page) for search; skip empty classes
    logic [CW-1:0]  nx_c;
    logic [PCW-1:0] nx_k;
    always_comb begin
        nx_c = r_sc;
        nx_k = r_sk + PCW'(1);
        if (nx_k >= r_pcnt[r_sc]) begin
            nx_k = '0;
            nx_c = r_sc + CW'(1);
            for (int j = 0; j < NUM_CLASSES; j++) begin
                if (32'(nx_c) < NUM_CLASSES && r_pcnt[nx_c] == '0) nx_c = nx_c + CW'(1);
            end
        end
    end

    logic [CW-1:0] first_c;
    always_comb begin
        first_c = '0;
        for (int j = 0; j < NUM_CLASSES; j++) begin
            if (32'(first_c) < NUM_CLASSES && r_pcnt[first_c] == '0)
                first_c = first_c + CW'(1);
        end
    end

    logic [55:0] pc_sum;
    assign pc_sum = (56'(r_size) + (56'd1 << r_ps) - 56'd1) >> r_ps;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_size  <= i_size;
            r_addr  <= AW'(i_address) & amask;
            r_spv   <= i_spare_valid;
            r_spare <= AW'(i_spare_page);
            r_ps    <= eff_ps;
            r_pmask <= ~((AW'(1) << eff_ps) - AW'(1));
            r_sused <= 1'b0;
            r_raddr <= '0;
            r_pcount <= '0;
        end
        if (i_cmd.decode) begin
            r_cls <= cls_c;
        end
        if (i_cmd.search_start) begin
            r_sc  <= first_c;
            r_sk  <= '0;
        end
        if (i_cmd.carve_start) begin
            r_carve_a <= spare_al;
            r_carve_i <= '0;
            r_carve_n <= ncarve;
            r_esh     <= esh_c;
            r_sused   <= 1'b1;
        end
        if (i_cmd.carve_step) begin
            r_carve_i <= r_carve_i + TW'(1);
            r_carve_a <= (r_carve_a + (AW'(1) << r_esh)) & amask;
        end
        if (i_cmd.search_step) begin
            r_sc <= nx_c;
            r_sk <= nx_k;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
            if (i_cmd.status == ST_LARGE) r_pcount <= 23'(pc_sum);
            if (i_cmd.status == ST_REGION) r_raddr <= 48'(pstart);
            if (i_cmd.pop_take) r_raddr <= 48'(rd_s);
        end
        if (i_cmd.out_load) begin
            o_status         <= r_status;
            o_result_address <= r_raddr;
            o_page_count     <= r_pcount;
            o_spare_used     <= r_sused;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_top[c]  <= '0;
                r_pcnt[c] <= '0;
            end
        end else begin
            if (i_cmd.carve_start) r_pcnt[cls_c] <= r_pcnt[cls_c] + PCW'(1);
            if (we_s) r_top[cls_sel] <= top_c + TW'(1);
            if (i_cmd.pop_rd) r_top[cls_sel] <= top_c - TW'(1);
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_rd |-> top_c != '0)
        else $error("pop from empty class stack");
    a_pcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.carve_start |-> r_pcnt[cls_c] < PCW'(MAX_PAGES_PER_CLASS))
        else $error("page table overflow");
    a_sused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.carve_start |=> r_sused)
        else $error("carve without spare flag");
endmodule
`default_nettype wire

>>> hdl/size_class_slab_allocator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// size_class_slab_allocator: power-of-two size-class slab allocator
//
//  Channel   Dir  Payload
//  s_axis    in   tdata: size, address, spare_page ; tuser: operation, spare_valid
//  m_axis    out  tdata: result_address, page_count ; tuser: status, spare_used
//  cfg       in   page_shift
//
//  A large, out-of-memory or table-full request goes from decode to done; a pop
//  reads and takes a stack element; a refill first writes min(2^(page_shift-class-3),
//  1820) elements to the stack memory (one element written per cycle), then pops; a
//  free search compares page table entries in turn and pushes the address on a hit.
//  Reset is synchronous; all stacks and page tables read empty after it.
//  One transaction at a time; a stalled result holds the controller in its
//  final state.
// ---------------------------------------------------------------------------
module size_class_slab_allocator #(
    parameter int NUM_CLASSES         = scsa_pkg::NUM_CLASSES_DEF,
    parameter int MAX_PAGES_PER_CLASS = scsa_pkg::MAX_PAGES_PER_CLASS_DEF,
    parameter int ADDR_BITS           = scsa_pkg::ADDR_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // size[31:0], address[79:32], spare_page[127:80]
    input  wire logic [1:0]   s_axis_tuser,  // operation[0], spare_valid[1]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata,  // result_address[47:0], page_count[70:48], pad
    output logic [3:0]        m_axis_tuser,  // status[2:0], spare_used[3]
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [4:0]   i_cfg_data
);
    import scsa_pkg::*;

    logic [4:0] r_page_shift;
    logic       r_out_valid;
    logic       in_fire, out_free, idle;
    t_cmd       cmd;
    t_sts       sts;
    logic [2:0]  st;
    logic [47:0] ra;
    logic [22:0] pc;
    logic        su;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = idle;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= 5'(PAGE_SHIFT_RESET);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_page_shift <= i_cfg_data;
            if (cmd.out_load)            r_out_valid <= 1'b1;
            else if (m_axis_tready)      r_out_valid <= 1'b0;
        end
    end

    scsa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire), .i_out_free(out_free),
        .i_sts(sts), .o_cmd(cmd), .o_idle(idle)
    );

    scsa_dp #(
        .NUM_CLASSES(NUM_CLASSES), .MAX_PAGES_PER_CLASS(MAX_PAGES_PER_CLASS),
        .ADDR_BITS(ADDR_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_page_shift(r_page_shift),
        .i_operation(s_axis_tuser[0]), .i_size(s_axis_tdata[31:0]),
        .i_address(s_axis_tdata[79:32]), .i_spare_valid(s_axis_tuser[1]),
        .i_spare_page(s_axis_tdata[127:80]), .o_sts(sts), .o_status(st),
        .o_result_address(ra), .o_page_count(pc), .o_spare_used(su)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, pc, ra};
    assign m_axis_tuser  = {su, st};
endmodule
`default_nettype wire
